// File: hdl/orthogonal_polynomial_series_eval_macros.svh
`ifndef ORTHOGONAL_POLYNOMIAL_SERIES_EVAL_MACROS_SVH
`define ORTHOGONAL_POLYNOMIAL_SERIES_EVAL_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define OPSE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define OPSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/opse_pkg.sv
`default_nettype none

package opse_pkg;

    // Series limits
    localparam int MAX_TERMS = 64;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int L_W       = $clog2(2 * MAX_TERMS);

    // Field widths
    localparam int X_W       = 32;
    localparam int COEF_W    = 32;
    localparam int BASIS_W   = 3;
    localparam int VALUE_W   = 40;

    // Fixed-point datapath widths
    localparam int FRAC_W    = 30;
    localparam int POLY_W    = 34;
    localparam int OPA_W     = 35;
    localparam int OPB_W     = 34;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int RES_W     = 36;
    localparam int T_W       = 38;
    localparam int SUM_W     = RES_W + $clog2(MAX_TERMS);
    localparam int RECIP_W   = FRAC_W;

    // Basis codes
    localparam logic [BASIS_W-1:0] BASIS_CHEB      = 3'd0;
    localparam logic [BASIS_W-1:0] BASIS_CHEB_EVEN = 3'd1;
    localparam logic [BASIS_W-1:0] BASIS_CHEB_ODD  = 3'd2;
    localparam logic [BASIS_W-1:0] BASIS_LEG       = 3'd3;
    localparam logic [BASIS_W-1:0] BASIS_LEG_EVEN  = 3'd4;
    localparam logic [BASIS_W-1:0] BASIS_LEG_ODD   = 3'd5;

    typedef enum logic [1:0] {
        VAR_FULL,
        VAR_EVEN,
        VAR_ODD
    } variant_t;

    typedef struct packed {
        logic     legendre;
        variant_t variant;
    } basis_dec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_ADV_M,
        ST_ADV_Q,
        ST_TERM,
        ST_FINISH
    } state_t;

    // Request to the shared multiplier: magnitudes and the product sign
    typedef struct packed {
        logic             start;
        logic             neg;
        logic [OPA_W-1:0] a;
        logic [OPB_W-1:0] b;
    } mul_req_t;

    // Rounded signed product, valid while done is high
    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] result;
    } mul_rsp_t;

    // Map a basis code to family and term selection; unused codes act as full Chebyshev
    function automatic basis_dec_t basis_decode(input logic [BASIS_W-1:0] code);
        basis_dec_t d;
        case (code)
            BASIS_CHEB_EVEN: d = '{legendre: 1'b0, variant: VAR_EVEN};
            BASIS_CHEB_ODD:  d = '{legendre: 1'b0, variant: VAR_ODD};
            BASIS_LEG:       d = '{legendre: 1'b1, variant: VAR_FULL};
            BASIS_LEG_EVEN:  d = '{legendre: 1'b1, variant: VAR_EVEN};
            BASIS_LEG_ODD:   d = '{legendre: 1'b1, variant: VAR_ODD};
            default:         d = '{legendre: 1'b0, variant: VAR_FULL};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hdl/opse_recip_rom.sv
`default_nettype none

module opse_recip_rom (
    input  wire logic [opse_pkg::L_W-1:0]     l,
    output logic      [opse_pkg::RECIP_W-1:0] recip
);
    import opse_pkg::*;

    localparam int DEPTH = 2 ** L_W;

    logic [RECIP_W-1:0] rom [DEPTH];

    // Build round(2^30 / l); entries below two hold the entry for two
    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        localparam longint LDIV  = (g < 2) ? 2 : g;
        localparam longint ENTRY = ((longint'(1) << FRAC_W) + LDIV / 2) / LDIV;
        assign rom[g] = RECIP_W'(ENTRY);
    end

    assign recip = rom[l];

endmodule

`default_nettype wire

// File: hdl/opse_mul_unit.sv
`default_nettype none

module opse_mul_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire opse_pkg::mul_req_t req,
    output opse_pkg::mul_rsp_t      rsp
);
    import opse_pkg::*;

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);

    logic [OPA_W-1:0]        a_reg;
    logic [OPB_W-1:0]        b_reg;
    logic                    neg_op_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_prod_reg;
    logic signed [RES_W-1:0] res_reg;
    logic [2:0]              valid_reg;

    logic [PROD_W-1:0]       rounded;
    logic signed [RES_W-1:0] mag_s;
    logic signed [RES_W-1:0] res_next;

    // Round to nearest, ties away from zero, then restore the sign
    assign rounded  = (prod_reg + HALF) >> FRAC_W;
    assign mag_s    = signed'(RES_W'(rounded));
    assign res_next = neg_prod_reg ? -mag_s : mag_s;

    // Track the request through operand, product and result stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[1:0], req.start};
        end
    end

    // Hold operands, multiply, round
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg      <= req.a;
            b_reg      <= req.b;
            neg_op_reg <= req.neg;
        end
        prod_reg     <= PROD_W'(a_reg) * PROD_W'(b_reg);
        neg_prod_reg <= neg_op_reg;
        res_reg      <= res_next;
    end

    assign rsp.done   = valid_reg[2];
    assign rsp.result = res_reg;

endmodule

`default_nettype wire

// File: hdl/orthogonal_polynomial_series_eval.sv
// Chebyshev / Legendre series evaluator.
// Input channel (s_*): one coefficient per request. The first request of a series
// also carries the point s_x (Q1.30) and s_basis; s_last closes the series.
// Result channel (m_*): one request per series, sent after the last coefficient:
// the sum in Q15.24 clipped to 40 bits, a clip flag and a term-limit flag.
// Throughput: the block takes a new coefficient only after it is through with the last.
// A coefficient takes one multiply on the shared multiplier for its term plus up to
// two recurrence steps, each one multiply for Chebyshev or two for Legendre (the
// division by l is a reciprocal-table multiply). Coefficients past the term limit
// take no multiply. s_ready is high only while the sequencer is idle.
// Reset: aresetn is synchronous, active low; the block returns to idle, awaits the
// first coefficient of a new series and drops any pending result.
// Stall: a result waits in the output register while m_ready is low and the next
// coefficient is still taken; a later result waits until that register frees.
`default_nettype none

module orthogonal_polynomial_series_eval (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [opse_pkg::X_W-1:0]        s_x,
    input  wire logic        [opse_pkg::BASIS_W-1:0]    s_basis,
    input  wire logic signed [opse_pkg::COEF_W-1:0]     s_coefficient,
    input  wire logic                                   s_last,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed      [opse_pkg::VALUE_W-1:0]    m_value,
    output logic                                        m_saturated,
    output logic                                        m_too_long
);
    import opse_pkg::*;

    localparam logic signed [POLY_W-1:0] ONE_Q30  = POLY_W'(1) << FRAC_W;
    localparam logic signed [T_W-1:0]    POLY_MAX = T_W'((longint'(1) << (POLY_W - 1)) - 1);
    localparam logic signed [T_W-1:0]    POLY_MIN = -(T_W'(longint'(1) << (POLY_W - 1)));
    localparam logic signed [SUM_W-1:0]  OUT_MAX  =
        SUM_W'((longint'(1) << (VALUE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0]  OUT_MIN  =
        -(SUM_W'(longint'(1) << (VALUE_W - 1)));

    // Control state
    state_t                   state_reg, state_next;
    logic                     in_series_reg, in_series_next;
    logic                     issued_reg, issued_next;
    logic [1:0]               steps_reg, steps_next;
    logic                     out_valid_reg, out_valid_next;

    // Series state
    logic signed [X_W-1:0]    point_reg, point_next;
    logic [BASIS_W-1:0]       basis_reg, basis_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [POLY_W-1:0] older_reg, older_next;
    logic signed [POLY_W-1:0] newer_reg, newer_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     ovf_reg, ovf_next;
    logic signed [COEF_W-1:0] coef_reg, coef_next;
    logic                     last_reg, last_next;
    logic [L_W-1:0]           l_reg, l_next;
    logic signed [RES_W-1:0]  m_reg, m_next;

    // Output register
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic                      out_sat_reg, out_sat_next;
    logic                      out_long_reg, out_long_next;

    // Datapath
    basis_dec_t               dec;
    mul_req_t                 req;
    mul_rsp_t                 rsp;
    logic [RECIP_W-1:0]       recip;
    logic signed [RES_W-1:0]  res;
    logic signed [X_W:0]      pt_ext, pt_abs;
    logic signed [COEF_W:0]   cf_ext, cf_abs;
    logic signed [POLY_W:0]   nw_ext, nw_abs;
    logic signed [POLY_W-1:0] p_sel;
    logic signed [POLY_W:0]   p_ext, p_abs;
    logic signed [T_W-1:0]    d_val, d_abs;
    logic signed [T_W-1:0]    t_cheb, t_leg;
    logic signed [POLY_W-1:0] sat_cheb, sat_leg;

    function automatic logic signed [POLY_W-1:0] sat_poly(input logic signed [T_W-1:0] t);
        logic signed [POLY_W-1:0] r;
        if (t > POLY_MAX) begin
            r = POLY_W'(POLY_MAX);
        end else if (t < POLY_MIN) begin
            r = POLY_W'(POLY_MIN);
        end else begin
            r = POLY_W'(t);
        end
        return r;
    endfunction

    assign dec = basis_decode(basis_reg);
    assign res = signed'(rsp.result);

    opse_recip_rom u_recip_rom (
        .l     (l_reg),
        .recip (recip)
    );

    opse_mul_unit u_mul_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // Operand magnitudes
    assign pt_ext = (X_W + 1)'(point_reg);
    assign pt_abs = pt_ext[X_W] ? -pt_ext : pt_ext;
    assign cf_ext = (COEF_W + 1)'(coef_reg);
    assign cf_abs = cf_ext[COEF_W] ? -cf_ext : cf_ext;
    assign nw_ext = (POLY_W + 1)'(newer_reg);
    assign nw_abs = nw_ext[POLY_W] ? -nw_ext : nw_ext;

    // Pick the polynomial value that weights this coefficient
    always_comb begin
        case (dec.variant)
            VAR_EVEN: p_sel = older_reg;
            VAR_ODD:  p_sel = newer_reg;
            default:  p_sel = (cnt_reg == '0) ? older_reg : newer_reg;
        endcase
    end
    assign p_ext = (POLY_W + 1)'(p_sel);
    assign p_abs = p_ext[POLY_W] ? -p_ext : p_ext;

    // Recurrence arithmetic
    assign d_val    = T_W'(m_reg) - T_W'(older_reg);
    assign d_abs    = d_val[T_W-1] ? -d_val : d_val;
    assign t_cheb   = (T_W'(res) <<< 1) - T_W'(older_reg);
    assign t_leg    = (T_W'(m_reg) <<< 1) - T_W'(older_reg) - T_W'(res);
    assign sat_cheb = sat_poly(t_cheb);
    assign sat_leg  = sat_poly(t_leg);

    // Sequence one coefficient through the shared multiplier
    always_comb begin
        state_next     = state_reg;
        in_series_next = in_series_reg;
        issued_next    = issued_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg;
        point_next     = point_reg;
        basis_next     = basis_reg;
        cnt_next       = cnt_reg;
        older_next     = older_reg;
        newer_next     = newer_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        coef_next      = coef_reg;
        last_next      = last_reg;
        l_next         = l_reg;
        m_next         = m_reg;
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;
        out_long_next  = out_long_reg;
        req            = '0;
        s_ready        = 1'b0;

        // Drop the result once the receiver takes it
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    coef_next  = s_coefficient;
                    last_next  = s_last;
                    state_next = ST_PLAN;
                    // Open a new series on its first coefficient
                    if (!in_series_reg) begin
                        point_next     = s_x;
                        basis_next     = s_basis;
                        cnt_next       = '0;
                        older_next     = ONE_Q30;
                        newer_next     = POLY_W'(s_x);
                        sum_next       = '0;
                        ovf_next       = 1'b0;
                        in_series_next = 1'b1;
                    end
                end
            end

            ST_PLAN: begin
                if (cnt_reg >= CNT_W'(MAX_TERMS)) begin
                    ovf_next   = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    if (dec.variant == VAR_FULL) begin
                        steps_next = (cnt_reg >= CNT_W'(2)) ? 2'd1 : 2'd0;
                        l_next     = L_W'(cnt_reg);
                    end else begin
                        steps_next = (cnt_reg != '0) ? 2'd2 : 2'd0;
                        l_next     = L_W'({cnt_reg, 1'b0});
                    end
                    if (steps_next != 2'd0) begin
                        state_next = ST_ADV_M;
                    end else begin
                        state_next = ST_TERM;
                    end
                end
            end

            ST_ADV_M: begin
                req.start   = !issued_reg;
                req.neg     = point_reg[X_W-1] ^ newer_reg[POLY_W-1];
                req.a       = OPA_W'(nw_abs);
                req.b       = OPB_W'(pt_abs);
                issued_next = 1'b1;
                if (rsp.done) begin
                    issued_next = 1'b0;
                    if (dec.legendre) begin
                        m_next     = res;
                        state_next = ST_ADV_Q;
                    end else begin
                        older_next = newer_reg;
                        newer_next = sat_cheb;
                        l_next     = l_reg + L_W'(1);
                        steps_next = steps_reg - 2'd1;
                        state_next = (steps_reg == 2'd1) ? ST_TERM : ST_ADV_M;
                    end
                end
            end

            ST_ADV_Q: begin
                req.start   = !issued_reg;
                req.neg     = d_val[T_W-1];
                req.a       = OPA_W'(d_abs);
                req.b       = OPB_W'(recip);
                issued_next = 1'b1;
                if (rsp.done) begin
                    issued_next = 1'b0;
                    older_next  = newer_reg;
                    newer_next  = sat_leg;
                    l_next      = l_reg + L_W'(1);
                    steps_next  = steps_reg - 2'd1;
                    state_next  = (steps_reg == 2'd1) ? ST_TERM : ST_ADV_M;
                end
            end

            ST_TERM: begin
                req.start   = !issued_reg;
                req.neg     = coef_reg[COEF_W-1] ^ p_sel[POLY_W-1];
                req.a       = OPA_W'(p_abs);
                req.b       = OPB_W'(cf_abs);
                issued_next = 1'b1;
                if (rsp.done) begin
                    issued_next = 1'b0;
                    sum_next    = sum_reg + SUM_W'(res);
                    cnt_next    = cnt_reg + CNT_W'(1);
                    state_next  = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!out_valid_reg || m_ready) begin
                    // Clip the sum into the output range and close the series
                    out_valid_next = 1'b1;
                    out_long_next  = ovf_reg;
                    if (sum_reg > OUT_MAX) begin
                        out_value_next = VALUE_W'(OUT_MAX);
                        out_sat_next   = 1'b1;
                    end else if (sum_reg < OUT_MIN) begin
                        out_value_next = VALUE_W'(OUT_MIN);
                        out_sat_next   = 1'b1;
                    end else begin
                        out_value_next = VALUE_W'(sum_reg);
                        out_sat_next   = 1'b0;
                    end
                    in_series_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_series_reg <= 1'b0;
            issued_reg    <= 1'b0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_series_reg <= in_series_next;
            issued_reg    <= issued_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold series and output payload
    always_ff @(posedge aclk) begin
        point_reg     <= point_next;
        basis_reg     <= basis_next;
        cnt_reg       <= cnt_next;
        older_reg     <= older_next;
        newer_reg     <= newer_next;
        sum_reg       <= sum_next;
        ovf_reg       <= ovf_next;
        coef_reg      <= coef_next;
        last_reg      <= last_next;
        l_reg         <= l_next;
        m_reg         <= m_next;
        out_value_reg <= out_value_next;
        out_sat_reg   <= out_sat_next;
        out_long_reg  <= out_long_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_value     = out_value_reg;
    assign m_saturated = out_sat_reg;
    assign m_too_long  = out_long_reg;

endmodule

`default_nettype wire

// File: hdl/opse_checker.sv
`default_nettype none

`include "orthogonal_polynomial_series_eval_macros.svh"

module opse_checker (
    input wire logic                                   aclk,
    input wire logic                                   aresetn,
    input wire logic                                   s_valid,
    input wire logic                                   s_ready,
    input wire logic signed [opse_pkg::X_W-1:0]        s_x,
    input wire logic        [opse_pkg::BASIS_W-1:0]    s_basis,
    input wire logic signed [opse_pkg::COEF_W-1:0]     s_coefficient,
    input wire logic                                   s_last,
    input wire logic                                   m_valid,
    input wire logic                                   m_ready,
    input wire logic signed [opse_pkg::VALUE_W-1:0]    m_value,
    input wire logic                                   m_saturated,
    input wire logic                                   m_too_long
);
    import opse_pkg::*;

    localparam logic [VALUE_W-1:0] CLIP_HI = {1'b0, {(VALUE_W - 1){1'b1}}};
    localparam logic [VALUE_W-1:0] CLIP_LO = {1'b1, {(VALUE_W - 1){1'b0}}};

    // A stalled result holds
    `OPSE_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_saturated) && $stable(m_too_long), "result changed while stalled")

    // The sequencer is busy right after taking a coefficient
    `OPSE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after accept")

    // A clipped sum sits at one of the range limits
    `OPSE_ASSERT_SAME(a_clip_value, aclk, aresetn, m_valid && m_saturated, (m_value == CLIP_HI) || (m_value == CLIP_LO), "clipped value off the limits")

    // A new result appears only after a busy cycle
    `OPSE_ASSERT_SAME(a_result_after_work, aclk, aresetn, $rose(m_valid), !$past(s_ready), "result raised while idle")

endmodule

bind orthogonal_polynomial_series_eval opse_checker u_opse_checker (.*);

`default_nettype wire
